### rtl/core/line_command_tokenizer_defines.svh
// assertion macros for the checker file
`ifndef LINE_COMMAND_TOKENIZER_DEFINES_SVH
`define LINE_COMMAND_TOKENIZER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define LCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line tokenizer check failed");

// next-cycle implication, disabled while reset is held
`define LCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line tokenizer check failed");

`endif

### rtl/core/lct_pkg.sv
`default_nettype none
package lct_pkg;

    // field widths of the token word
    localparam int CNT_W      = 4;
    localparam int TEXT_W     = 64;
    localparam int OUT_DATA_W = 80;

    // parameter defaults
    localparam int MAX_ARGS_DEF    = 8;
    localparam int TOKEN_BYTES_DEF = 8;

    // characters with a meaning to the parser
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // token kinds on tuser
    localparam logic KIND_NAME = 1'b0;
    localparam logic KIND_ARG  = 1'b1;

    // parse phase of the current line
    typedef enum logic [1:0] {
        PH_NAME = 2'd0,
        PH_ARGS = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    // line parser state held in flops
    typedef struct packed {
        t_phase              phase;
        logic [TEXT_W-1:0]   name;
        logic [CNT_W-1:0]    name_len;
        logic [TEXT_W-1:0]   cur;
        logic [CNT_W-1:0]    cur_len;
        logic [CNT_W-1:0]    found;
        logic                stopped;
    } t_pstate;

    // one parser step: new state plus an argument memory write request
    typedef struct packed {
        t_pstate             st;
        logic                wr;
        logic [CNT_W-1:0]    wr_idx;
    } t_pstep;

endpackage
`default_nettype wire

### rtl/core/line_command_tokenizer.sv
// first token: after its LF word is taken it passes the emitter issue register, the read stage and the output register
// throughput: one input byte per cycle, one token per cycle while m_axis_tready is high
// a byte that follows CR stalls until the previous run has left the argument memory read stage
// reset: synchronous active low, clears parser and emitter control; argument memory is not reset
// argument memory: two banks of 1 << AW entries, parser writes one bank while emitter reads the other
`default_nettype none
module line_command_tokenizer
    import lct_pkg::*;
#(
    parameter int MAX_ARGS    = MAX_ARGS_DEF,
    parameter int TOKEN_BYTES = TOKEN_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave side, tdata: in_byte[7:0]
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,
    // master side, tdata: token_index[3:0], token_text[67:4], token_length[71:68],
    // arg_count[75:72], zero[79:76]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: token_kind[0]
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast
);

    localparam int TW    = 8 * TOKEN_BYTES;
    localparam int AW    = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam int DEPTH = 2 * (1 << AW);
    localparam int MW    = CNT_W + TW;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ARGS);

    // append a byte to a token, dropping bytes beyond TOKEN_BYTES
    function automatic t_pstate append_name(t_pstate s, logic [7:0] b);
        t_pstate r;
        r = s;
        for (int j = 0; j < TOKEN_BYTES; j++) begin
            if (s.name_len == CNT_W'(j)) begin
                r.name[8*j +: 8] = b;
            end
        end
        if (s.name_len < CNT_W'(TOKEN_BYTES)) begin
            r.name_len = s.name_len + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic t_pstate append_cur(t_pstate s, logic [7:0] b);
        t_pstate r;
        r = s;
        for (int j = 0; j < TOKEN_BYTES; j++) begin
            if (s.cur_len == CNT_W'(j)) begin
                r.cur[8*j +: 8] = b;
            end
        end
        if (s.cur_len < CNT_W'(TOKEN_BYTES)) begin
            r.cur_len = s.cur_len + CNT_W'(1);
        end
        return r;
    endfunction

    // one character through the line parser
    function automatic t_pstep take_char(t_pstate s, logic [7:0] b);
        t_pstep r;
        r.st     = s;
        r.wr     = 1'b0;
        r.wr_idx = s.found;
        case (s.phase)
            PH_NAME: begin
                if (b == CH_LP) begin
                    r.st.phase = PH_ARGS;
                end else begin
                    r.st = append_name(s, b);
                end
            end
            PH_ARGS: begin
                if (b == CH_RP) begin
                    // final argument is stored when not stopped and there is room, counted only when non-empty
                    r.wr = !s.stopped && (s.found < MAX_CNT);
                    if (r.wr && (s.cur_len != '0)) begin
                        r.st.found = s.found + CNT_W'(1);
                    end
                    r.st.phase = PH_DONE;
                end else if (s.stopped) begin
                    r.st = s;
                end else if (b == CH_COMMA) begin
                    if (s.found >= MAX_CNT) begin
                        r.st.stopped = 1'b1;
                    end else begin
                        r.wr         = 1'b1;
                        r.st.found   = s.found + CNT_W'(1);
                        r.st.cur     = '0;
                        r.st.cur_len = '0;
                    end
                end else if (s.found < MAX_CNT) begin
                    r.st = append_cur(s, b);
                end
            end
            default: begin
                r.st = s;
            end
        endcase
        return r;
    endfunction

    // parser registers
    t_pstate          r_ps, n_ps;
    logic             r_pcr, n_pcr;
    logic             r_bank, n_bank;

    // emitter registers
    logic             r_em_busy;
    logic [CNT_W-1:0] r_em_idx;
    logic [CNT_W-1:0] r_em_cnt;
    logic             r_em_bank;
    logic [TW-1:0]    r_em_name;
    logic [CNT_W-1:0] r_em_name_len;

    // read stage
    logic             r_s1_v;
    logic             r_s1_kind;
    logic [CNT_W-1:0] r_s1_idx;
    logic             r_s1_last;
    logic [MW-1:0]    r_rd_q;

    // output register
    logic             r_ov;
    logic             r_out_kind;
    logic [CNT_W-1:0] r_out_idx;
    logic [TEXT_W-1:0] r_out_text;
    logic [CNT_W-1:0] r_out_len;
    logic [CNT_W-1:0] r_out_cnt;
    logic             r_out_last;

    // argument memory
    logic [MW-1:0]    r_arg_mem [0:DEPTH-1];

    logic             in_hs;
    logic             line_end;
    logic             em_free;
    logic             em_issue;
    logic             out_ld;
    logic             rd_en;
    logic [AW:0]      rd_addr;
    logic [CNT_W-1:0] idx_m1;
    logic             mem_we;
    logic [AW:0]      wr_addr;
    logic [MW-1:0]    wr_data;
    t_pstep           step1, step2;
    t_pstate          clr;

    assign em_free  = !r_em_busy && !r_s1_v;
    assign in_hs    = s_axis_tvalid && s_axis_tready;
    assign line_end = in_hs && r_pcr && (s_axis_tdata == CH_LF);

    // next parser state: pending CR resolves as a character, then the new byte
    always_comb begin
        clr          = '0;
        clr.phase    = PH_NAME;
        step1.st     = r_ps;
        step1.wr     = 1'b0;
        step1.wr_idx = r_ps.found;
        if (r_pcr) begin
            step1 = take_char(r_ps, CH_CR);
        end
        step2 = take_char(step1.st, s_axis_tdata);
        n_ps   = r_ps;
        n_pcr  = r_pcr;
        n_bank = r_bank;
        if (in_hs && (s_axis_tdata != CH_NUL)) begin
            if (line_end) begin
                n_ps   = clr;
                n_pcr  = 1'b0;
                n_bank = !r_bank;
            end else if (s_axis_tdata == CH_CR) begin
                n_ps  = step1.st;
                n_pcr = 1'b1;
            end else begin
                n_ps  = step2.st;
                n_pcr = 1'b0;
            end
        end
    end

    // parser outputs: ready and memory write
    always_comb begin
        s_axis_tready = !r_pcr || em_free;
        mem_we  = in_hs && (s_axis_tdata != CH_NUL) && !line_end &&
                  (s_axis_tdata != CH_CR) && step2.wr;
        wr_addr = {r_bank, step2.wr_idx[AW-1:0]};
        wr_data = {step1.st.cur_len, step1.st.cur[TW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps.phase    <= PH_NAME;
            r_ps.name     <= '0;
            r_ps.name_len <= '0;
            r_ps.cur      <= '0;
            r_ps.cur_len  <= '0;
            r_ps.found    <= '0;
            r_ps.stopped  <= 1'b0;
            r_pcr         <= 1'b0;
            r_bank        <= 1'b0;
        end else begin
            r_ps   <= n_ps;
            r_pcr  <= n_pcr;
            r_bank <= n_bank;
        end
    end

    // emitter issue: name first, then one memory read per argument
    assign out_ld   = r_s1_v && (!r_ov || m_axis_tready);
    assign em_issue = r_em_busy && (!r_s1_v || out_ld);
    assign idx_m1   = r_em_idx - CNT_W'(1);
    assign rd_en    = em_issue && (r_em_idx != '0);
    assign rd_addr  = {r_em_bank, idx_m1[AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_busy <= 1'b0;
            r_em_idx  <= '0;
            r_em_cnt  <= '0;
            r_em_bank <= 1'b0;
            r_s1_v    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (line_end) begin
                r_em_busy <= 1'b1;
                r_em_idx  <= '0;
                r_em_cnt  <= (r_ps.phase == PH_DONE) ? r_ps.found : '0;
                r_em_bank <= r_bank;
            end else if (em_issue) begin
                r_em_idx <= r_em_idx + CNT_W'(1);
                if (r_em_idx == r_em_cnt) begin
                    r_em_busy <= 1'b0;
                end
            end
            if (em_issue) begin
                r_s1_v <= 1'b1;
            end else if (out_ld) begin
                r_s1_v <= 1'b0;
            end
            if (out_ld) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // emitter payload
    always_ff @(posedge i_clk) begin
        if (line_end) begin
            r_em_name     <= (r_ps.phase == PH_DONE) ? r_ps.name[TW-1:0] : '0;
            r_em_name_len <= (r_ps.phase == PH_DONE) ? r_ps.name_len : '0;
        end
        if (em_issue) begin
            r_s1_kind <= (r_em_idx != '0) ? KIND_ARG : KIND_NAME;
            r_s1_idx  <= (r_em_idx != '0) ? idx_m1 : '0;
            r_s1_last <= (r_em_idx == r_em_cnt);
        end
        if (out_ld) begin
            r_out_kind <= r_s1_kind;
            r_out_idx  <= r_s1_idx;
            r_out_last <= r_s1_last;
            r_out_cnt  <= r_em_cnt;
            if (r_s1_kind == KIND_ARG) begin
                r_out_text <= TEXT_W'(r_rd_q[TW-1:0]);
                r_out_len  <= r_rd_q[MW-1:TW];
            end else begin
                r_out_text <= TEXT_W'(r_em_name);
                r_out_len  <= r_em_name_len;
            end
        end
    end

    // argument memory: banks never overlap between write and read, so no forwarding
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_arg_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_q <= r_arg_mem[rd_addr];
        end
    end

    // output packing
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {4'b0, r_out_cnt, r_out_len, r_out_text, r_out_idx};

endmodule
`default_nettype wire

### rtl/core/lct_checker.sv
`default_nettype none
`include "line_command_tokenizer_defines.svh"
module lct_checker
    import lct_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  m_axis_tuser,
    input  wire logic                  m_axis_tlast
);

    logic [CNT_W-1:0] tok_idx;
    logic [CNT_W-1:0] tok_cnt;
    logic             tok_arg;
    logic             in_unused;

    assign tok_idx   = m_axis_tdata[3:0];
    assign tok_cnt   = m_axis_tdata[75:72];
    assign tok_arg   = m_axis_tvalid && (m_axis_tuser == KIND_ARG);
    assign in_unused = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata);

    // stalled word holds
    `LCT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // argument index stays below the count of its line
    `LCT_ASSERT_NOW(a_arg_idx, i_clk, i_rst_n, tok_arg, tok_idx < tok_cnt)
    // name token has index zero and ends the run only when there are no arguments
    `LCT_ASSERT_NOW(a_name_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, (tok_idx == '0) && (m_axis_tlast == (tok_cnt == '0)))
    // last marks the final argument
    `LCT_ASSERT_NOW(a_arg_last, i_clk, i_rst_n, tok_arg, m_axis_tlast == ((tok_idx + 4'd1) == tok_cnt))
    // input side stays a known value during traffic
    `LCT_ASSERT_NOW(a_in_known, i_clk, i_rst_n, s_axis_tvalid, !$isunknown(in_unused))

endmodule

bind line_command_tokenizer lct_checker u_lct_checker (.*);
`default_nettype wire

### bench/tb_line_command_tokenizer.sv
`default_nettype none
module tb_line_command_tokenizer;
    import lct_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 38;
    localparam int RAND_BYTES   = 50;

    // one token word as the block emits it
    typedef struct packed {
        logic              kind;
        logic [CNT_W-1:0]  idx;
        logic [TEXT_W-1:0] text;
        logic [CNT_W-1:0]  len;
        logic [CNT_W-1:0]  cnt;
        logic              is_last;
    } t_tok;

    // directed line: body, optional nul insert position, optional typed single token
    typedef struct {
        string body;
        int    nul_at;
        bit    typed;
        string name_want;
    } t_line_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'h00;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    line_command_tokenizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // in_byte[7:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // index, text, length, count, zero
        .m_axis_tuser  (m_axis_tuser),    // token_kind[0]
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow parser state
    t_phase            ph;
    logic              cr_held;
    logic [TEXT_W-1:0] cmd_text;
    logic [CNT_W-1:0]  cmd_len;
    logic [TEXT_W-1:0] arg_text [MAX_ARGS_DEF];
    logic [CNT_W-1:0]  arg_len [MAX_ARGS_DEF];
    logic [CNT_W-1:0]  arg_num;
    logic              arg_halt;

    t_tok       line_run[$];      // tokens caused by the latest byte
    t_tok       token_queue[$];   // tokens still owed by the block
    logic [7:0] line_bytes[$];

    int  err_count = 0;
    int  tokens_checked = 0;
    int  bytes_sent = 0;
    int  lines_sent = 0;
    int  full_runs = 0;
    int  idle_pct = IDLE_PCT;
    bit  stall_request = 1'b0;
    int  hold_cnt = 0;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t token %0d: %s got %0h want %0h", $time, tokens_checked, what, got, want);
        err_count++;
    endtask

    function automatic void clear_line();
        ph = PH_NAME;
        cmd_text = '0;
        cmd_len = '0;
        for (int i = 0; i < MAX_ARGS_DEF; i++) begin
            arg_text[i] = '0;
            arg_len[i] = '0;
        end
        arg_num = '0;
        arg_halt = 1'b0;
    endfunction

    // add one character to a token, dropping what does not fit
    function automatic void grow_token(ref logic [TEXT_W-1:0] text, ref logic [CNT_W-1:0] len,
                                       input logic [7:0] ch);
        if (len < TOKEN_BYTES_DEF) begin
            text[8*len +: 8] = ch;
            len = len + 1'b1;
        end
    endfunction

    function automatic void parse_char(input logic [7:0] ch);
        case (ph)
            PH_NAME: begin
                if (ch == CH_LP)
                    ph = PH_ARGS;
                else
                    grow_token(cmd_text, cmd_len, ch);
            end
            PH_ARGS: begin
                if (ch == CH_RP) begin
                    if (!arg_halt && arg_num < MAX_ARGS_DEF && arg_len[arg_num] > 0)
                        arg_num = arg_num + 1'b1;
                    ph = PH_DONE;
                end else if (arg_halt) begin
                    // collection halted, nothing more to store
                end else if (ch == CH_COMMA) begin
                    if (arg_num >= MAX_ARGS_DEF)
                        arg_halt = 1'b1;
                    else
                        arg_num = arg_num + 1'b1;
                end else if (arg_num < MAX_ARGS_DEF) begin
                    grow_token(arg_text[arg_num], arg_len[arg_num], ch);
                end
            end
            default: begin
                // after the closing parenthesis everything waits for the line end
            end
        endcase
    endfunction

    // token run for a finished line
    function automatic void close_line();
        t_tok t;
        if (ph != PH_DONE) begin
            t = '{KIND_NAME, '0, '0, '0, '0, 1'b1};
            line_run.push_back(t);
        end else begin
            t = '{KIND_NAME, '0, cmd_text, cmd_len, arg_num, arg_num == 0};
            line_run.push_back(t);
            for (int i = 0; i < arg_num; i++) begin
                t = '{KIND_ARG, CNT_W'(i), arg_text[i], arg_len[i], arg_num, i + 1 == arg_num};
                line_run.push_back(t);
            end
            if (arg_num == MAX_ARGS_DEF)
                full_runs++;
        end
        clear_line();
    endfunction

    // predict the tokens one input byte causes
    function automatic void tokenize_byte(input logic [7:0] ch);
        line_run.delete();
        if (ch == CH_NUL)
            return;
        if (cr_held) begin
            cr_held = 1'b0;
            if (ch == CH_LF) begin
                close_line();
                return;
            end
            // lone carriage return is an ordinary character
            parse_char(CH_CR);
        end
        if (ch == CH_CR)
            cr_held = 1'b1;
        else
            parse_char(ch);
    endfunction

    function automatic t_tok name_only(input string s);
        t_tok t;
        t = '{KIND_NAME, '0, '0, '0, '0, 1'b1};
        for (int i = 0; i < s.len(); i++)
            t.text[8*i +: 8] = s[i];
        t.len = CNT_W'(s.len());
        return t;
    endfunction

    // offer one byte with random gaps and wait for it to be taken
    task automatic send_byte(input logic [7:0] ch);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // send line_bytes, predicting as each byte is taken
    task automatic send_line(input bit typed, input t_tok typed_tok);
        foreach (line_bytes[k]) begin
            send_byte(line_bytes[k]);
            tokenize_byte(line_bytes[k]);
            if (typed && line_run.size() > 0)
                token_queue.push_back(typed_tok);
            else
                foreach (line_run[j]) token_queue.push_back(line_run[j]);
        end
        lines_sent++;
    endtask

    function automatic logic [7:0] content_char();
        logic [7:0] c;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return CH_NUL;
        if (roll < 8)
            return CH_CR;
        do c = 8'($urandom_range(1, 255));
        while (c == CH_LP || c == CH_RP || c == CH_COMMA || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 7))
            0: return CH_LP;
            1: return CH_RP;
            2: return CH_COMMA;
            3: return CH_CR;
            4: return CH_LF;
            5: return CH_NUL;
            6: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well formed commands with random content, some noise
    function automatic void build_line();
        int n_args;
        line_bytes.delete();
        if ($urandom_range(0, 99) < 82) begin
            repeat ($urandom_range(0, 10)) line_bytes.push_back(content_char());
            line_bytes.push_back(CH_LP);
            n_args = $urandom_range(0, 10);
            for (int a = 0; a < n_args; a++) begin
                if (a > 0)
                    line_bytes.push_back(CH_COMMA);
                repeat ($urandom_range(0, 4)) line_bytes.push_back(content_char());
            end
            if ($urandom_range(0, 9) != 0)
                line_bytes.push_back(CH_RP);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) line_bytes.push_back(content_char());
        end else begin
            repeat ($urandom_range(1, 12)) line_bytes.push_back(noise_char());
        end
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
    endfunction

    // token sink: random ready, one long hold-off, compare each word
    always @(posedge i_clk) begin
        t_tok want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (token_queue.size() == 0) begin
                    flag_mismatch("unexpected token, data", m_axis_tdata[67:4], '0);
                end else begin
                    want = token_queue.pop_front();
                    if (m_axis_tuser !== want.kind)
                        flag_mismatch("kind", m_axis_tuser, want.kind);
                    if (m_axis_tdata[3:0] !== want.idx)
                        flag_mismatch("index", m_axis_tdata[3:0], want.idx);
                    if (m_axis_tdata[67:4] !== want.text)
                        flag_mismatch("text", m_axis_tdata[67:4], want.text);
                    if (m_axis_tdata[71:68] !== want.len)
                        flag_mismatch("length", m_axis_tdata[71:68], want.len);
                    if (m_axis_tdata[75:72] !== want.cnt)
                        flag_mismatch("arg count", m_axis_tdata[75:72], want.cnt);
                    if (m_axis_tlast !== want.is_last)
                        flag_mismatch("last", m_axis_tlast, want.is_last);
                end
                tokens_checked++;
            end
            if (stall_request && hold_cnt < HOLD_CYCLES) begin
                hold_cnt <= hold_cnt + 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // directed lines, each sent with CR LF appended
    t_line_row dir_rows[] = '{
        '{"",                         -1, 1'b1, ""},
        '{"go",                       -1, 1'b1, ""},
        '{"go(ab",                    -1, 1'b1, ""},
        '{"(a,b",                     -1, 1'b1, ""},
        '{"()",                       -1, 1'b1, ""},
        '{"abcdefghijk()",            -1, 1'b1, "abcdefgh"},
        '{"a),b(x)",                  -1, 1'b0, ""},
        '{"f(,,)",                    -1, 1'b0, ""},
        '{"x(,)",                     -1, 1'b0, ""},
        '{"f(1,2,3,4,5,6,7,8,9,0)",   -1, 1'b0, ""},
        '{"f(abcdefghij,\377\377)",   -1, 1'b0, ""},
        '{"ab(x)junk,(y",             -1, 1'b0, ""},
        '{"a(b)",                      1, 1'b0, ""},
        '{"a(b)",                      5, 1'b0, ""},
        '{"c\015(\015x)",             -1, 1'b0, ""},
        '{"d(y)\015",                 -1, 1'b0, ""},
        '{"\377(\377)",               -1, 1'b0, ""}
    };

    // stimulus
    initial begin
        int rand_start_bytes;
        int rand_lines;
        string s;
        cr_held = 1'b0;
        clear_line();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_rows[r]) begin
            s = dir_rows[r].body;
            line_bytes.delete();
            for (int k = 0; k < s.len(); k++) line_bytes.push_back(s[k]);
            line_bytes.push_back(CH_CR);
            line_bytes.push_back(CH_LF);
            if (dir_rows[r].nul_at >= 0)
                line_bytes.insert(dir_rows[r].nul_at, CH_NUL);
            send_line(dir_rows[r].typed, name_only(dir_rows[r].name_want));
        end

        // sink holds off while full argument lines keep coming
        stall_request = 1'b1;
        for (int n = 0; n < 2; n++) begin
            s = "p(a,b,c,d,e,f,g,h)";
            line_bytes.delete();
            for (int k = 0; k < s.len(); k++) line_bytes.push_back(s[k]);
            line_bytes.push_back(CH_CR);
            line_bytes.push_back(CH_LF);
            send_line(1'b0, '0);
        end

        // sender pauses until the backlog is gone
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (token_queue.size() != 0) @(posedge i_clk);

        // random part, the first line runs with neither side idling
        rand_start_bytes = bytes_sent;
        rand_lines = 0;
        while (bytes_sent - rand_start_bytes < RAND_BYTES) begin
            idle_pct = (rand_lines == 0) ? 0 : IDLE_PCT;
            build_line();
            send_line(1'b0, '0);
            rand_lines++;
        end

        // drain
        s_axis_tvalid <= 1'b0;
        idle_pct = IDLE_PCT;
        @(posedge i_clk);
        while (token_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run covered %0d lines, %0d bytes, %0d tokens checked",
                 lines_sent, bytes_sent, tokens_checked);
        $display("lines with a full argument list: %0d, mismatches: %0d",
                 full_runs, err_count);
        if (err_count == 0 && token_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/lct_pkg.sv
rtl/core/line_command_tokenizer.sv
rtl/core/lct_checker.sv
bench/tb_line_command_tokenizer.sv
